// ===== src/ssa_pkg.sv =====
package ssa_pkg;

   // Field and register widths
   localparam int PULSE_W    = 12;
   localparam int CMD_W      = 12;
   localparam int RATE_W     = 16;
   localparam int ACCUM_W    = 32;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   // Change arithmetic
   localparam int MS_PER_SEC = 1000;
   // 1000 * max span (4095) fits in 22 bits
   localparam int DIV_W      = 22;
   // quotient bits below the saturation point
   localparam int QUO_W      = ACCUM_W - 1;
   localparam int CNT_W      = $clog2(QUO_W);

   // Reset values
   localparam logic [PULSE_W-1:0] MIN_PULSE_RST   = 12'd500;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RST   = 12'd2500;
   localparam logic [PULSE_W-1:0] PULSE_NOW_RST   = 12'd1500;
   localparam logic [RATE_W-1:0]  RATE_RST        = 16'd180;
   localparam logic [CMD_W-1:0]   MIN_COMMAND_RST = 12'd0;
   localparam logic [CMD_W-1:0]   MAX_COMMAND_RST = 12'd4095;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_COMMAND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_COMMAND = 3'd4;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_LIFT  = 2'd1,
      OP_LOWER = 2'd2,
      OP_APPLY = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_RATE,
      ST_MUL_ELAPSED,
      ST_DIV_CHECK,
      ST_DIV_STEP,
      ST_ACCUM
   } state_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [CMD_W-1:0]   speed_command;
   } req_payload_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_width;
      logic               moved;
   } rsp_payload_type;

endpackage

// ===== src/servo_slew_accumulator.sv =====
// Channel    | Direction | Handshake                  | Payload
// req_       | in        | req_valid / req_stall      | opcode, speed_command
// rsp_       | out       | rsp_valid / rsp_stall      | pulse_width, moved
// csr_       | in        | csr_write_en (no wait)     | csr_index, csr_wdata
//
// Tick and apply finish in the accept cycle, which also loads the result register.
// Lift and lower run 2 multiply stages, a range check and a 31-step restoring divider by
// 1000 * command span; a saturating change skips the divider, a zero span all but
// the first multiply. One item is in flight; req_stall is high meanwhile.
// Synchronous reset restores registers and state; a stalled result holds new input off.
module servo_slew_accumulator
   import ssa_pkg::*;
#(
   parameter int FRAC_BITS    = 16,
   parameter int ELAPSED_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PROD1_W = RATE_W + CMD_W;
   localparam int P_W     = PROD1_W + ELAPSED_BITS;
   localparam int SH      = QUO_W - FRAC_BITS;
   localparam int HIGH_W  = P_W - SH;
   localparam int CMP_W   = (HIGH_W > DIV_W) ? HIGH_W : DIV_W;
   localparam int IP_W    = ACCUM_W - FRAC_BITS;
   localparam int NP_W    = ((IP_W > PULSE_W) ? IP_W : PULSE_W) + 2;

   // Configuration registers
   logic [PULSE_W-1:0]      min_pulse_ff, max_pulse_ff;
   logic [RATE_W-1:0]       rate_ff;
   logic [CMD_W-1:0]        min_command_ff, max_command_ff;

   // Architectural state
   logic [PULSE_W-1:0]      pulse_ff, pulse_in;
   logic [ACCUM_W-1:0]      accum_ff, accum_in;
   logic [ELAPSED_BITS-1:0] elapsed_ff, elapsed_in;

   // Sequencer and datapath
   state_type               state_ff, state_in;
   logic                    lower_ff;
   logic                    span_zero_ff;
   logic [CMD_W-1:0]        diff_ff;
   logic [PROD1_W-1:0]      prod1_ff;
   logic [DIV_W-1:0]        d_ff;
   logic [P_W-1:0]          p_ff;
   logic [DIV_W-1:0]        rem_ff;
   logic [QUO_W-1:0]        low_ff;
   logic [QUO_W-1:0]        q_ff;
   logic                    ovf_ff;
   logic [CNT_W-1:0]        cnt_ff;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_payload_ff;

   logic                    out_free;
   logic                    req_accept;
   logic                    rsp_load;
   logic                    moved_in;

   // Command clamp and span
   logic [CMD_W-1:0]        cmd_lo, cmd_clamped, span;
   logic                    span_zero;

   // Divider step
   logic [HIGH_W-1:0]       p_high;
   logic [DIV_W:0]          trial;
   logic                    trial_ge;

   // Accumulate and apply
   logic [QUO_W-1:0]        change;
   logic [ACCUM_W:0]        sum;
   logic [ACCUM_W-1:0]      mag;
   logic [IP_W-1:0]         ip_mag;
   logic [FRAC_BITS-1:0]    frac;
   logic signed [NP_W-1:0]  np, pulse_ext, ip_ext, min_ext, max_ext;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Sequencer: next state and input stall
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            if (req_accept && (req_payload.opcode == OP_LIFT ||
                               req_payload.opcode == OP_LOWER)) begin
               state_in = ST_MUL_RATE;
            end
         end
         ST_MUL_RATE: begin
            state_in = span_zero_ff ? ST_ACCUM : ST_MUL_ELAPSED;
         end
         ST_MUL_ELAPSED: begin
            state_in = ST_DIV_CHECK;
         end
         ST_DIV_CHECK: begin
            state_in = (CMP_W'(p_high) >= CMP_W'(d_ff)) ? ST_ACCUM : ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Command clamp: raise to min, then lower to max
   always_comb begin
      cmd_lo      = (req_payload.speed_command < min_command_ff) ? min_command_ff
                                                                 : req_payload.speed_command;
      cmd_clamped = (cmd_lo > max_command_ff) ? max_command_ff : cmd_lo;
      span_zero   = (max_command_ff <= min_command_ff);
      span        = max_command_ff - min_command_ff;
   end

   // Divider: high part of p << FRAC_BITS seeds the remainder, low bits shift in
   assign p_high   = p_ff[P_W-1:SH];
   assign trial    = {rem_ff, low_ff[QUO_W-1]};
   assign trial_ge = (trial >= {1'b0, d_ff});

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               lower_ff     <= (req_payload.opcode == OP_LOWER);
               span_zero_ff <= span_zero;
               diff_ff      <= cmd_clamped - min_command_ff;
            end
         end
         ST_MUL_RATE: begin
            prod1_ff <= PROD1_W'(rate_ff) * PROD1_W'(diff_ff);
            d_ff     <= DIV_W'(span) * DIV_W'(MS_PER_SEC);
            q_ff     <= '0;
            ovf_ff   <= 1'b0;
         end
         ST_MUL_ELAPSED: begin
            p_ff <= P_W'(prod1_ff) * P_W'(elapsed_ff);
         end
         ST_DIV_CHECK: begin
            ovf_ff <= (CMP_W'(p_high) >= CMP_W'(d_ff));
            rem_ff <= DIV_W'(p_high);
            low_ff <= {p_ff[SH-1:0], FRAC_BITS'(0)};
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         ST_DIV_STEP: begin
            rem_ff <= trial_ge ? DIV_W'(trial - {1'b0, d_ff}) : trial[DIV_W-1:0];
            q_ff   <= {q_ff[QUO_W-2:0], trial_ge};
            low_ff <= {low_ff[QUO_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // State update for every opcode
   always_comb begin
      accum_in   = accum_ff;
      pulse_in   = pulse_ff;
      elapsed_in = elapsed_ff;
      rsp_load   = 1'b0;
      moved_in   = 1'b0;

      change = ovf_ff ? {QUO_W{1'b1}} : q_ff;
      sum    = '0;

      mag       = accum_ff[ACCUM_W-1] ? (ACCUM_W'(0) - accum_ff) : accum_ff;
      ip_mag    = mag[ACCUM_W-1:FRAC_BITS];
      frac      = mag[FRAC_BITS-1:0];
      pulse_ext = NP_W'(pulse_ff);
      ip_ext    = NP_W'(ip_mag);
      min_ext   = NP_W'(min_pulse_ff);
      max_ext   = NP_W'(max_pulse_ff);
      np        = accum_ff[ACCUM_W-1] ? (pulse_ext - ip_ext) : (pulse_ext + ip_ext);

      if (req_accept) begin
         case (req_payload.opcode)
            OP_TICK: begin
               if (!(&elapsed_ff)) begin
                  elapsed_in = elapsed_ff + ELAPSED_BITS'(1);
               end
               rsp_load = 1'b1;
            end
            OP_APPLY: begin
               elapsed_in = '0;
               rsp_load   = 1'b1;
               // magnitude of one or more moves the truncated integer part
               if (ip_mag != '0) begin
                  accum_in = accum_ff[ACCUM_W-1] ? (ACCUM_W'(0) - ACCUM_W'(frac))
                                                 : ACCUM_W'(frac);
                  if (np < min_ext) begin
                     pulse_in = min_pulse_ff;
                  end else if (np > max_ext) begin
                     pulse_in = max_pulse_ff;
                  end else begin
                     pulse_in = np[PULSE_W-1:0];
                  end
                  moved_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // Lift/lower: reversal replaces, same direction adds with saturation
      if (state_ff == ST_ACCUM && out_free) begin
         rsp_load = 1'b1;
         if (!lower_ff) begin
            sum = {accum_ff[ACCUM_W-1], accum_ff} + (ACCUM_W + 1)'(change);
            if (accum_ff[ACCUM_W-1] || accum_ff == '0) begin
               accum_in = ACCUM_W'(change);
            end else if (sum[ACCUM_W] != sum[ACCUM_W-1]) begin
               accum_in = {1'b0, {(ACCUM_W - 1){1'b1}}};
            end else begin
               accum_in = sum[ACCUM_W-1:0];
            end
         end else begin
            sum = {accum_ff[ACCUM_W-1], accum_ff} - (ACCUM_W + 1)'(change);
            if (!accum_ff[ACCUM_W-1]) begin
               accum_in = ACCUM_W'(0) - ACCUM_W'(change);
            end else if (sum[ACCUM_W] != sum[ACCUM_W-1]) begin
               accum_in = {1'b1, {(ACCUM_W - 1){1'b0}}};
            end else begin
               accum_in = sum[ACCUM_W-1:0];
            end
         end
      end

      // Result register
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff     <= PULSE_NOW_RST;
         accum_ff     <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pulse_ff     <= pulse_in;
         accum_ff     <= accum_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff.pulse_width <= pulse_in;
         rsp_payload_ff.moved       <= moved_in;
      end
   end

   // Configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff   <= MIN_PULSE_RST;
         max_pulse_ff   <= MAX_PULSE_RST;
         rate_ff        <= RATE_RST;
         min_command_ff <= MIN_COMMAND_RST;
         max_command_ff <= MAX_COMMAND_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_PULSE:   min_pulse_ff   <= csr_wdata[PULSE_W-1:0];
            CSR_MAX_PULSE:   max_pulse_ff   <= csr_wdata[PULSE_W-1:0];
            CSR_RATE:        rate_ff        <= csr_wdata[RATE_W-1:0];
            CSR_MIN_COMMAND: min_command_ff <= csr_wdata[CMD_W-1:0];
            CSR_MAX_COMMAND: max_command_ff <= csr_wdata[CMD_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== tb/sv/servo_slew_monitor.sv =====
// Watches both channels and the register port, predicts each result of the
// slew controller and compares it field by field with what comes back.
module servo_slew_monitor
   import ssa_pkg::*;
#(
   parameter int FRAC_BITS    = 16,
   parameter int ELAPSED_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_payload_type       rsp_payload,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding
);

   localparam longint ONE     = longint'(1) << FRAC_BITS;
   localparam longint ACC_MAX = 64'h7FFF_FFFF;
   localparam longint ACC_MIN = -ACC_MAX - 1;

   // register copies
   logic [PULSE_W-1:0] pulse_floor;
   logic [PULSE_W-1:0] pulse_ceiling;
   logic [RATE_W-1:0]  slew_rate;
   logic [CMD_W-1:0]   cmd_zero;
   logic [CMD_W-1:0]   cmd_full;

   // controller state
   logic [PULSE_W-1:0]      pulse_us;
   logic signed [31:0]      accum;
   logic [ELAPSED_BITS-1:0] elapsed;

   rsp_payload_type pulse_expect_q[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   function automatic logic signed [31:0] sat32(longint v);
      if (v > ACC_MAX) return ACC_MAX[31:0];
      if (v < ACC_MIN) return ACC_MIN[31:0];
      return v[31:0];
   endfunction

   // Change magnitude in fixed point: elapsed * rate * normalized speed / 1000,
   // saturated to the largest positive accumulator value.
   function automatic logic [31:0] slew_change(logic [CMD_W-1:0] cmd);
      logic [CMD_W-1:0] c;
      logic [63:0]      span, prod, div, quo, rem, mag;
      if (cmd_full <= cmd_zero) return '0;
      c = cmd;
      if (c < cmd_zero) c = cmd_zero;
      if (c > cmd_full) c = cmd_full;
      span = 64'(cmd_full - cmd_zero);
      prod = 64'(elapsed) * 64'(slew_rate) * 64'(c - cmd_zero);
      div  = 64'(MS_PER_SEC) * span;
      quo  = prod / div;
      rem  = prod % div;
      if (quo >= (64'd1 << (31 - FRAC_BITS))) return ACC_MAX[31:0];
      mag = (quo << FRAC_BITS) + ((rem << FRAC_BITS) / div);
      if (mag > 64'(ACC_MAX)) mag = 64'(ACC_MAX);
      return mag[31:0];
   endfunction

   // Advances the state by one command and returns the result it causes.
   function automatic rsp_payload_type predict_slew(req_payload_type item);
      rsp_payload_type res;
      longint          chg, acc, mag, ip, np;
      res.moved = 1'b0;
      case (item.opcode)
         OP_TICK: begin
            if (elapsed != '1) elapsed = elapsed + ELAPSED_BITS'(1);
         end
         OP_LIFT: begin
            chg = longint'(slew_change(item.speed_command));
            // a reversal from lowering starts over
            if (accum <= 0) accum = sat32(chg);
            else accum = sat32(longint'(accum) + chg);
         end
         OP_LOWER: begin
            chg = longint'(slew_change(item.speed_command));
            if (accum >= 0) accum = sat32(-chg);
            else accum = sat32(longint'(accum) - chg);
         end
         OP_APPLY: begin
            elapsed = '0;
            acc = longint'(accum);
            // whole microseconds move into the pulse, the fraction stays
            if (acc >= ONE || acc <= -ONE) begin
               mag = (acc < 0) ? -acc : acc;
               ip  = mag >>> FRAC_BITS;
               if (acc < 0) ip = -ip;
               accum = 32'(acc - ip * ONE);
               np = longint'(pulse_us) + ip;
               if (np < longint'(pulse_floor)) np = longint'(pulse_floor);
               else if (np > longint'(pulse_ceiling)) np = longint'(pulse_ceiling);
               pulse_us  = np[PULSE_W-1:0];
               res.moved = 1'b1;
            end
         end
      endcase
      res.pulse_width = pulse_us;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         pulse_floor   = MIN_PULSE_RST;
         pulse_ceiling = MAX_PULSE_RST;
         slew_rate     = RATE_RST;
         cmd_zero      = MIN_COMMAND_RST;
         cmd_full      = MAX_COMMAND_RST;
         pulse_us      = PULSE_NOW_RST;
         accum         = '0;
         elapsed       = '0;
         pulse_expect_q.delete();
      end else begin
         // register writes; unknown indexes are ignored
         if (csr_write_en) begin
            case (csr_index)
               CSR_MIN_PULSE:   pulse_floor   = csr_wdata[PULSE_W-1:0];
               CSR_MAX_PULSE:   pulse_ceiling = csr_wdata[PULSE_W-1:0];
               CSR_RATE:        slew_rate     = csr_wdata[RATE_W-1:0];
               CSR_MIN_COMMAND: cmd_zero      = csr_wdata[CMD_W-1:0];
               CSR_MAX_COMMAND: cmd_full      = csr_wdata[CMD_W-1:0];
               default: ;
            endcase
         end

         // result transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pulse_expect_q.size() == 0) begin
               report_mismatch("unexpected result, pulse_width",
                               int'(rsp_payload.pulse_width), -1);
            end else begin
               want = pulse_expect_q.pop_front();
               if (rsp_payload.pulse_width !== want.pulse_width)
                  report_mismatch("pulse_width", int'(rsp_payload.pulse_width),
                                  int'(want.pulse_width));
               if (rsp_payload.moved !== want.moved)
                  report_mismatch("moved", int'(rsp_payload.moved), int'(want.moved));
            end
         end

         // command transfer
         if (req_valid && !req_stall) pulse_expect_q.push_back(predict_slew(req_payload));
      end
      outstanding = pulse_expect_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import ssa_pkg::*;

   localparam int FRAC_BITS    = 16;
   localparam int ELAPSED_BITS = 16;
   localparam int RESET_CYCLES = 12;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 120;
   localparam int LONG_TICKS   = 520;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 40;
   localparam int CSR_SLOTS    = 2 ** CSR_IDX_W;
   localparam int CSR_FIRST_UNUSED = CSR_MAX_COMMAND + 1;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   int mismatches;
   int outstanding;
   int phase_num     = -1;
   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   int quiet_cycles  = 0;

   // command range currently loaded, used to aim commands at its edges
   logic [CMD_W-1:0] cmd_lo = MIN_COMMAND_RST;
   logic [CMD_W-1:0] cmd_hi = MAX_COMMAND_RST;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   servo_slew_accumulator #(
      .FRAC_BITS    (FRAC_BITS),
      .ELAPSED_BITS (ELAPSED_BITS)
   ) dut (.*);

   servo_slew_monitor #(
      .FRAC_BITS    (FRAC_BITS),
      .ELAPSED_BITS (ELAPSED_BITS)
   ) monitor (.*);

   // watchdog: too long without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("servo_slew_accumulator regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, plus one long hold-off each in phases 1 and 6
   initial begin : receiver
      int hold_left;
      int held_phase;
      hold_left  = 0;
      held_phase = -1;
      forever begin
         @(negedge clock);
         if ((phase_num == 1 || phase_num == 6) && phase_num != held_phase) begin
            held_phase = phase_num;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   // Offers one command and returns at the falling edge after its transfer.
   // Valid stays high so a following command goes out back to back.
   task automatic offer_item(opcode_type op, logic [CMD_W-1:0] cmd);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{opcode: op, speed_command: cmd};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // drop valid and wait for the block to drain
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_settings(int minp, int maxp, int rate, int mincmd, int maxcmd);
      logic [31:0] junk;
      settle();
      junk = $urandom;
      // upper bits of the narrow registers are noise and must be dropped
      write_reg(CSR_MIN_PULSE,   {junk[3:0],   minp[11:0]});
      write_reg(CSR_MAX_PULSE,   {junk[7:4],   maxp[11:0]});
      write_reg(CSR_RATE,        rate[15:0]);
      write_reg(CSR_MIN_COMMAND, {junk[11:8],  mincmd[11:0]});
      write_reg(CSR_MAX_COMMAND, {junk[15:12], maxcmd[11:0]});
      for (int i = CSR_FIRST_UNUSED; i < CSR_SLOTS; i++) begin
         write_reg(i[CSR_IDX_W-1:0], CSR_DATA_W'($urandom));
      end
      cmd_lo = mincmd[11:0];
      cmd_hi = maxcmd[11:0];
   endtask

   function automatic logic [CMD_W-1:0] pick_command();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return CMD_W'(cmd_lo - 1'b1 + $urandom_range(2));
         3: return CMD_W'(cmd_hi - 1'b1 + $urandom_range(2));
         default: return CMD_W'($urandom);
      endcase
   endfunction

   task automatic run_directed();
      // apply with an empty accumulator only restarts the count
      offer_item(OP_APPLY, '0);
      // nothing elapsed yet: zero change either way
      offer_item(OP_LIFT, '0);
      offer_item(OP_LOWER, '1);
      repeat (6) offer_item(OP_TICK, 12'hAAA);
      offer_item(OP_LIFT, '1);
      offer_item(OP_LIFT, 12'h7FF);
      offer_item(OP_APPLY, 12'h555);
      // reversal replaces the leftover fraction
      repeat (5) offer_item(OP_TICK, '1);
      offer_item(OP_LOWER, '1);
      offer_item(OP_LOWER, 12'hAAA);
      offer_item(OP_APPLY, '0);
      offer_item(OP_TICK, 12'h555);
      offer_item(OP_LIFT, 12'h555);
      offer_item(OP_APPLY, '1);
   endtask

   // Mostly tick runs followed by moves and usually an apply; some pure noise.
   task automatic run_random(int count);
      int sent;
      int ticks;
      int moves;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 12) begin
            offer_item(opcode_type'($urandom_range(3)), CMD_W'($urandom));
            sent++;
         end else begin
            ticks = ($urandom_range(29) == 0) ? $urandom_range(600) : $urandom_range(8);
            moves = $urandom_range(4, 1);
            repeat (ticks) offer_item(OP_TICK, CMD_W'($urandom));
            repeat (moves) offer_item($urandom_range(1) ? OP_LIFT : OP_LOWER, pick_command());
            sent += ticks + moves;
            if ($urandom_range(9) < 7) begin
               offer_item(OP_APPLY, CMD_W'($urandom));
               sent++;
            end
         end
      end
   endtask

   task automatic setup_phase(int p);
      int lo;
      case (p)
         // widest limits, fastest rate
         1: load_settings(0, 4095, 65535, 0, 4095);
         // zero rate and zero command span
         2: load_settings(1000, 2000, 0, 2048, 2048);
         // inverted pulse limits and inverted span
         3: load_settings(3000, 1000, 4000, 3000, 100);
         // span of one, slowest nonzero rate
         4: load_settings(400, 2600, 1, 100, 101);
         // narrow random span
         7: begin
            lo = $urandom_range(4090);
            load_settings($urandom_range(4095), $urandom_range(4095), $urandom_range(65535),
                          lo, lo + $urandom_range(5, 1));
         end
         default: begin
            load_settings($urandom_range(4095), $urandom_range(4095), $urandom_range(65535),
                          $urandom_range(4095), $urandom_range(4095));
         end
      endcase
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 32;
      rcv_idle_pct  = 58;
      run_directed();

      for (int p = 0; p < PHASES; p++) begin
         if (p < 3) begin
            send_idle_pct = 32;
            rcv_idle_pct  = 58;
         end else if (p < 6) begin
            send_idle_pct = 58;
            rcv_idle_pct  = 32;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         if (p != 0) setup_phase(p);
         phase_num = p;
         run_random(PHASE_ITEMS);
      end

      // long elapsed count: slow lift, then full rate saturates change and accumulator
      load_settings(0, 4095, 1, 0, 4095);
      repeat (LONG_TICKS) offer_item(OP_TICK, CMD_W'($urandom));
      offer_item(OP_LIFT, '1);
      load_settings(0, 4095, 65535, 0, 4095);
      offer_item(OP_LIFT, '1);
      offer_item(OP_LIFT, '1);
      offer_item(OP_APPLY, '0);

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("servo_slew_accumulator regression: pass");
      end else begin
         $display("servo_slew_accumulator regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/ssa_pkg.sv
src/servo_slew_accumulator.sv
tb/sv/servo_slew_monitor.sv
tb/sv/tb.sv
